>>> rtl/mart_pkg.sv
// Shared constants, codes and types for the address region table.
package mart_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned TOTAL_W = 6;
  localparam int unsigned CAP_W   = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // result codes
  localparam logic [CODE_W-1:0] RES_OK   = 2'd0;
  localparam logic [CODE_W-1:0] RES_MISS = 2'd1;
  localparam logic [CODE_W-1:0] RES_FULL = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic [TAG_W-1:0]  owner;
  } entry_t;

endpackage

>>> rtl/mart_if.sv
// Handshake channel interfaces: request, response and configuration.
interface mart_req_if;
  logic                             valid;
  logic                             ready;
  logic [mart_pkg::ACT_W-1:0]       action;
  logic [mart_pkg::ADDR_W-1:0]      address;
  logic [mart_pkg::ADDR_W-1:0]      region_size;
  logic [mart_pkg::TAG_W-1:0]       handler_tag;

  modport source (output valid, action, address, region_size, handler_tag, input ready);
  modport sink   (input valid, action, address, region_size, handler_tag, output ready);
endinterface

interface mart_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [mart_pkg::CODE_W-1:0]      result_code;
  logic [mart_pkg::TAG_W-1:0]       matched_tag;
  logic [mart_pkg::TOTAL_W-1:0]     entry_total;

  modport source (output valid, result_code, matched_tag, entry_total, input ready);
  modport sink   (input valid, result_code, matched_tag, entry_total, output ready);
endinterface

interface mart_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mart_pkg::CAP_W-1:0]       capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

>>> rtl/mmio_address_range_table.sv
// Sorted address region table with insert, clear and binary-search lookup.
// Lookup: binary search, each probe reading the midpoint entry and then comparing against it
//   (at most 6 probes over 32 entries). Insert: shift each entry with a larger base up a slot,
//   then write the new one; empty-table and refused inserts, clear and no-op go straight to the result.
// A new item is taken only once the result of the last one has loaded into the output register;
//   a stalled result holds the block. Reset: count zero, limit 32, output empty, entries kept.
module mmio_address_range_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  mart_req_if.sink    req_i,
  mart_rsp_if.source  rsp_o,
  mart_cfg_if.sink    cfg_i
);
  import mart_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LK_PROBE = 3'd1; // pick midpoint, read it
  localparam logic [2:0] ST_LK_CMP   = 3'd2; // compare against probed entry
  localparam logic [2:0] ST_INS_CMP  = 3'd3; // shift entry up or drop new one in
  localparam logic [2:0] ST_INS_PUT  = 3'd4; // new entry lands at slot 0
  localparam logic [2:0] ST_RESP     = 3'd5; // hand result to the output register

  logic [2:0] state_q, state_d;

  // table state
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] limit_q;

  // item held during processing
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] size_q;
  logic [TAG_W-1:0]  tag_q;

  // search window and insert cursor
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic [IDX_W-1:0] mid_q, mid_d;

  // pending result
  logic [CODE_W-1:0] res_code_q, res_code_d;
  logic [TAG_W-1:0]  res_tag_q, res_tag_d;

  // output register
  logic               out_valid_q;
  logic [CODE_W-1:0]  out_code_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_load;

  // entry memory, one write and one registered read per cycle
  entry_t           mem_q [ENTRIES];
  entry_t           rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;

  logic accept;
  assign accept = req_i.valid & req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // full when at the configured limit or at the physical depth
  logic full;
  assign full = (count_q >= CNT_W'(limit_q)) || (count_q >= CNT_W'(ENTRIES));

  // shared compare unit: address against probed entry, end taken at 65 bits
  logic [ADDR_W:0] end_sum;
  logic            below, past;
  assign end_sum = {1'b0, rd_q.base} + {1'b0, rd_q.length};
  assign below   = addr_q < rd_q.base;
  assign past    = {1'b0, addr_q} >= end_sum;

  logic [CNT_W-1:0] cnt_m1, pos_m1, pos_m2, mid_p1;
  logic [CNT_W:0]   lo_hi_sum;
  assign cnt_m1    = count_q - CNT_W'(1);
  assign pos_m1    = pos_q - CNT_W'(1);
  assign pos_m2    = pos_q - CNT_W'(2);
  assign mid_p1    = CNT_W'(mid_q) + CNT_W'(1);
  assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};

  entry_t new_entry;
  assign new_entry = '{base: addr_q, length: size_q, owner: tag_q};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    pos_d      = pos_q;
    mid_d      = mid_q;
    res_code_d = res_code_q;
    res_tag_d  = res_tag_q;
    we         = 1'b0;
    waddr      = pos_q[IDX_W-1:0];
    wdata      = new_entry;
    raddr      = mid_q;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_code_d = RES_OK;
          res_tag_d  = '0;
          state_d    = ST_RESP;
          case (req_i.action)
            ACT_LOOKUP: begin
              res_code_d = RES_MISS;
              lo_d       = '0;
              hi_d       = count_q;
              state_d    = ST_LK_PROBE;
            end
            ACT_INSERT: begin
              if (full) begin
                res_code_d = RES_FULL;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = '{base: req_i.address, length: req_i.region_size,
                            owner: req_i.handler_tag};
                count_d = count_q + CNT_W'(1);
              end else begin
                pos_d   = count_q;
                raddr   = cnt_m1[IDX_W-1:0];
                state_d = ST_INS_CMP;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LK_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = lo_hi_sum[IDX_W:1];
          raddr   = lo_hi_sum[IDX_W:1];
          state_d = ST_LK_CMP;
        end else begin
          state_d = ST_RESP;
        end
      end

      ST_LK_CMP: begin
        if (below) begin
          hi_d    = CNT_W'(mid_q);
          state_d = ST_LK_PROBE;
        end else if (past) begin
          lo_d    = mid_p1;
          state_d = ST_LK_PROBE;
        end else begin
          res_code_d = RES_OK;
          res_tag_d  = rd_q.owner;
          state_d    = ST_RESP;
        end
      end

      ST_INS_CMP: begin
        // rd_q holds entry pos-1
        we = 1'b1;
        if (below) begin
          wdata = rd_q;
          pos_d = pos_m1;
          if (pos_m1 == '0) begin
            state_d = ST_INS_PUT;
          end else begin
            raddr = pos_m2[IDX_W-1:0];
          end
        end else begin
          count_d = count_q + CNT_W'(1);
          state_d = ST_RESP;
        end
      end

      ST_INS_PUT: begin
        we      = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      limit_q     <= CAP_RESET;
      lo_q        <= '0;
      hi_q        <= '0;
      pos_q       <= '0;
      mid_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      pos_q   <= pos_d;
      mid_q   <= mid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        limit_q <= cfg_i.capacity_limit;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item payload and results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= req_i.address;
      size_q <= req_i.region_size;
      tag_q  <= req_i.handler_tag;
    end
    res_code_q <= res_code_d;
    res_tag_q  <= res_tag_d;
    if (out_load) begin
      out_code_q  <= res_code_q;
      out_tag_q   <= res_tag_q;
      out_total_q <= TOTAL_W'(count_q);
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_code = out_code_q;
  assign rsp_o.matched_tag = out_tag_q;
  assign rsp_o.entry_total = out_total_q;

endmodule

>>> dv/tb_mmio_address_range_table.sv
// Self-checking testbench for the sorted address region table.
module tb_mmio_address_range_table;
  import mart_pkg::*;

  // The package names three actions; the fourth encoding must act as a no-op.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // The limit below covers ten times the worst case of block time, a sender gap and a receiver
  // stall per item, over roughly 950 items.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned MIX_ITEMS   = 90;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [TAG_W-1:0]   tag;
    logic [TOTAL_W-1:0] total;
  } region_rsp_t;

  // Mirror of the region table plus the queue of responses still owed.
  class region_table_checker;
    logic [ADDR_W-1:0] base_tab  [ENTRIES];
    logic [ADDR_W-1:0] len_tab   [ENTRIES];
    logic [TAG_W-1:0]  owner_tab [ENTRIES];
    int unsigned       held;
    logic [CAP_W-1:0]  cap;
    region_rsp_t       due_q[$];
    int unsigned       errors, n_items, n_hit, n_miss, n_full;

    function new();
      held = 0;
      cap = CAP_RESET;
      errors = 0;
      n_items = 0;
      n_hit = 0;
      n_miss = 0;
      n_full = 0;
    endfunction

    // Update the mirror for one accepted item and queue the response it owes.
    function void apply_request(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] addr,
                                logic [ADDR_W-1:0] size, logic [TAG_W-1:0] tag);
      region_rsp_t r;
      int unsigned lo, hi, mid, limit, pos;
      logic [ADDR_W:0] stop;
      bit found;
      r.code = RES_OK;
      r.tag = '0;
      n_items++;
      case (act)
        ACT_LOOKUP: begin
          r.code = RES_MISS;
          lo = 0;
          hi = held;
          found = 1'b0;
          while (lo < hi && !found) begin
            mid = (lo + hi) / 2;
            // end of region at 65 bits: a region reaching past 2^64 never ends below addr
            stop = {1'b0, base_tab[mid]} + {1'b0, len_tab[mid]};
            if (addr < base_tab[mid]) hi = mid;
            else if ({1'b0, addr} >= stop) lo = mid + 1;
            else begin
              found = 1'b1;
              r.code = RES_OK;
              r.tag = owner_tab[mid];
            end
          end
          if (found) n_hit++;
          else n_miss++;
        end
        ACT_INSERT: begin
          limit = (cap < ENTRIES) ? cap : ENTRIES;
          if (held >= limit) begin
            r.code = RES_FULL;
            n_full++;
          end else begin
            pos = held;
            while (pos > 0 && base_tab[pos-1] > addr) begin
              base_tab[pos]  = base_tab[pos-1];
              len_tab[pos]   = len_tab[pos-1];
              owner_tab[pos] = owner_tab[pos-1];
              pos--;
            end
            base_tab[pos]  = addr;
            len_tab[pos]   = size;
            owner_tab[pos] = tag;
            held++;
          end
        end
        ACT_CLEAR: held = 0;
        default: ;
      endcase
      r.total = TOTAL_W'(held);
      due_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task match_response(logic [CODE_W-1:0] code, logic [TAG_W-1:0] tag,
                        logic [TOTAL_W-1:0] total);
      region_rsp_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected response code=%0d tag=%0h total=%0d", code, tag, total));
      end else begin
        want = due_q.pop_front();
        if (code !== want.code)
          report($sformatf("result_code %0d, want %0d", code, want.code));
        if (tag !== want.tag)
          report($sformatf("matched_tag %0h, want %0h", tag, want.tag));
        if (total !== want.total)
          report($sformatf("entry_total %0d, want %0d", total, want.total));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned idle_pct;   // chance of a gap/stall burst, 0 = back to back
  int unsigned cycles;

  mart_req_if req_if();
  mart_rsp_if rsp_if();
  mart_cfg_if cfg_if();

  region_table_checker sb = new();

  mmio_address_range_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: the only other way out of the run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles, sb.due_q.size());
    $display("FAIL");
    $finish;
  end

  // Response side: ready stays high except for random stall bursts.
  initial begin
    rsp_if.ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct / 2) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Sample pre-edge values: the same ones the block sees at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.match_response(rsp_if.result_code, rsp_if.matched_tag, rsp_if.entry_total);
  end

  // Present one item, optionally after a gap, and hold it until accepted.
  // This task lowers valid only for a gap, so back-to-back items keep it high.
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                          input logic [ADDR_W-1:0] size, input logic [TAG_W-1:0] tag);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.address     <= addr;
    req_if.region_size <= size;
    req_if.handler_tag <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    sb.apply_request(act, addr, size, tag);
  endtask

  // Every item answers once, so an empty queue means the block is idle.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_if.valid          <= 1'b1;
    cfg_if.capacity_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.cap = value;
  endtask

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly small regions clustered in a few windows so lookups and sorting
  // see neighbors and equal bases; some zero-length, some fully random,
  // some running past the top of the address space.
  function automatic void pick_region(output logic [ADDR_W-1:0] b,
                                      output logic [ADDR_W-1:0] s);
    logic [31:0] upper;
    int unsigned mode;
    mode = $urandom_range(9);
    case ($urandom_range(3))
      0: upper = 32'h0;
      1: upper = 32'h8000_0000;
      2: upper = 32'hFFFF_FFFF;
      default: upper = $urandom;
    endcase
    b = {upper, 32'($urandom_range(4095)) << 8};
    s = 64'($urandom_range(1, 512));
    if (mode == 7) begin
      s = '0;
    end else if (mode == 8) begin
      b = rand64();
      s = rand64();
    end else if (mode == 9) begin
      b = {32'hFFFF_FFFF, $urandom};
      s = rand64() | 64'h8000_0000_0000_0000;
    end
  endfunction

  // Lookups aim mostly at edges and interiors of held regions.
  function automatic logic [ADDR_W-1:0] lookup_addr();
    int unsigned i;
    logic [ADDR_W-1:0] b, l;
    if (sb.held != 0 && $urandom_range(3) != 0) begin
      i = $urandom_range(sb.held - 1);
      b = sb.base_tab[i];
      l = sb.len_tab[i];
      case ($urandom_range(4))
        0: return b;
        1: return b + l - 1;
        2: return b + l;
        3: return b - 1;
        default: return (l == 0) ? b : b + (rand64() % l);
      endcase
    end
    return rand64();
  endfunction

  task automatic run_mix(input int unsigned n);
    logic [ADDR_W-1:0] b, s;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_req(ACT_LOOKUP, lookup_addr(), rand64(), 8'($urandom));
      end else if (r < 95) begin
        pick_region(b, s);
        send_req(ACT_INSERT, b, s, 8'($urandom));
      end else if (r < 98) begin
        send_req(ACT_CLEAR, rand64(), rand64(), 8'($urandom));
      end else begin
        send_req(ACT_UNUSED, rand64(), rand64(), 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps [10];
    int unsigned rates [4];
    caps  = '{6'd63, 6'd5, 6'd32, 6'd0, 6'd1, 6'd20, 6'd33, 6'd2, 6'd63, 6'd32};
    rates = '{0, 10, 30, 60};

    rst_ni                = 1'b0;
    idle_pct              = 0;
    req_if.valid          = 1'b0;
    req_if.action         = ACT_LOOKUP;
    req_if.address        = '0;
    req_if.region_size    = '0;
    req_if.handler_tag    = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.capacity_limit = CAP_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, capacity at its reset value.
    send_req(ACT_LOOKUP, '0, '0, '0);                           // empty table misses
    send_req(ACT_UNUSED, '1, '1, '1);                           // unused action is a no-op
    send_req(ACT_INSERT, 64'h1000, 64'h100, 8'h11);
    send_req(ACT_INSERT, '0, '0, 8'h00);                        // zero-length at the bottom
    send_req(ACT_INSERT, '1, '1, 8'hFF);                        // end carries past 2^64
    send_req(ACT_INSERT, 64'h1000, 64'h10, 8'h22);              // equal base goes after
    send_req(ACT_INSERT, 64'h8000_0000_0000_0000, 64'h1, 8'hA5);
    send_req(ACT_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h5A);
    send_req(ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'hC3);
    send_req(ACT_LOOKUP, '0, '1, '1);                           // zero-length never hits
    send_req(ACT_LOOKUP, 64'hFFF, '0, '0);
    send_req(ACT_LOOKUP, 64'h1000, '0, '0);
    send_req(ACT_LOOKUP, 64'h10FF, '0, '0);
    send_req(ACT_LOOKUP, 64'h1100, '0, '0);
    send_req(ACT_LOOKUP, '1, '0, '0);
    send_req(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0, '0);
    send_req(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send_req(ACT_UNUSED, '0, '0, '0);
    send_req(ACT_CLEAR, '1, '1, '1);
    send_req(ACT_LOOKUP, 64'h1000, '0, '0);                     // cleared table misses
    send_req(ACT_INSERT, '0, '1, 8'h00);                        // ends exactly at the top
    send_req(ACT_LOOKUP, '1, '0, '0);
    send_req(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);

    // Random phases, each under a new capacity. Phases don't clear first, so a
    // lowered limit often sits below the held count. The last phase runs flat out.
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      idle_pct = (p == 9) ? 0 : rates[$urandom_range(3)];
      run_mix(MIX_ITEMS);
    end

    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("ran %0d items: %0d lookup hits, %0d misses, %0d refused inserts",
             sb.n_items, sb.n_hit, sb.n_miss, sb.n_full);
    $display("capacity limits 0 to 63 with table depths up to %0d, %0d mismatches",
             ENTRIES, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mart_pkg.sv
rtl/mart_if.sv
rtl/mmio_address_range_table.sv
dv/tb_mmio_address_range_table.sv
